// File: sv/lrupr_pkg.sv
`default_nettype none

package lrupr_pkg;

    localparam int FC_W      = 5;
    localparam int IN_PAGE_W = 16;
    localparam int OUT_PAGE_W = 16;
    localparam int CNT_W     = 32;

    localparam logic [FC_W-1:0]  FC_RESET = FC_W'(4);
    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

    typedef struct packed {
        logic update;
        logic flush;
        logic hit;
        logic free_avail;
    } t_cmd;

endpackage

`default_nettype wire

// File: sv/lru_page_replacement.sv
// LRU page replacement, fully associative, built as a row of frame cells.
// Input channel: i_in_valid / o_in_ready carry one page reference (i_page).
// Output channel: o_out_valid / i_out_ready carry one result per reference:
// o_fault, o_evicted_valid, o_evicted_page and the saturating o_fault_total.
// Config channel: i_cfg_valid / o_cfg_ready write frame_count; the write
// flushes all frames and keeps the fault count. Write only while idle.
// Throughput: one reference per cycle while the output is not stalled. The
// reference is held in r_key; each cell compares its page with it in
// parallel; hit, rank, free-frame and victim data ripple along the row and
// all cells update in the same cycle, so the next lookup sees new state.
// A stalled output holds the result register and the pending reference;
// o_in_ready drops until the result is taken.
// Reset: all frames invalid, ranks zero, fault count zero, frame_count 4.
// Ready for references as soon as reset is released.
`default_nettype none

module lru_page_replacement #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire  [lrupr_pkg::IN_PAGE_W-1:0] i_page,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic                           o_fault,
    output logic                           o_evicted_valid,
    output logic [lrupr_pkg::OUT_PAGE_W-1:0] o_evicted_page,
    output logic [lrupr_pkg::CNT_W-1:0]    o_fault_total,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [lrupr_pkg::FC_W-1:0]     i_cfg_frame_count
);
    import lrupr_pkg::*;

    localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW     = ($clog2(MAX_FRAMES + 1) > FC_W) ? $clog2(MAX_FRAMES + 1) : FC_W;

    logic                 r_busy;
    logic [PAGE_BITS-1:0] r_key;
    logic                 r_out_valid;
    logic                 r_fault;
    logic                 r_ev_valid;
    logic [OUT_PAGE_W-1:0] r_ev_page;
    logic [CNT_W-1:0]     r_fault_cnt;
    logic [FC_W-1:0]      r_frame_count;

    logic [CW-1:0]        w_fc;
    logic [CW-1:0]        w_act;
    logic [RANK_W-1:0]    w_last_rank;
    logic                 w_proceed;
    logic                 w_evict;
    t_cmd                 w_cmd;

    logic [MAX_FRAMES:0]                 w_hit;
    logic [MAX_FRAMES:0][RANK_W-1:0]     w_rank;
    logic [MAX_FRAMES:0]                 w_free;
    logic [MAX_FRAMES:0][PAGE_BITS-1:0]  w_vpage;
    logic [MAX_FRAMES-1:0]               w_match;

    assign w_fc  = CW'(r_frame_count);
    assign w_act = (r_frame_count == '0)       ? CW'(1) :
                   (w_fc > CW'(MAX_FRAMES))    ? CW'(MAX_FRAMES) : w_fc;
    assign w_last_rank = RANK_W'(w_act - CW'(1));

    assign w_proceed  = r_busy && (!r_out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_busy || w_proceed);
    assign o_cfg_ready = i_rst_n;

    assign w_cmd.update     = w_proceed;
    assign w_cmd.flush      = i_cfg_valid;
    assign w_cmd.hit        = w_hit[MAX_FRAMES];
    assign w_cmd.free_avail = w_free[MAX_FRAMES];

    assign w_evict = !w_hit[MAX_FRAMES] && !w_free[MAX_FRAMES];

    assign w_hit[0]   = 1'b0;
    assign w_rank[0]  = '0;
    assign w_free[0]  = 1'b0;
    assign w_vpage[0] = '0;

    for (genvar gi = 0; gi < MAX_FRAMES; gi++) begin : g_cell
        lrupr_cell #(
            .PAGE_W (PAGE_BITS),
            .RANK_W (RANK_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_active      (CW'(gi) < w_act),
            .i_key         (r_key),
            .i_last_rank   (w_last_rank),
            .i_hit_rank    (w_rank[MAX_FRAMES]),
            .i_hit_chain   (w_hit[gi]),
            .i_rank_chain  (w_rank[gi]),
            .i_free_chain  (w_free[gi]),
            .i_vpage_chain (w_vpage[gi]),
            .o_hit_chain   (w_hit[gi+1]),
            .o_rank_chain  (w_rank[gi+1]),
            .o_free_chain  (w_free[gi+1]),
            .o_vpage_chain (w_vpage[gi+1]),
            .o_match       (w_match[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_fault_cnt   <= '0;
            r_frame_count <= FC_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_frame_count <= i_cfg_frame_count;
            end
            if (i_in_valid && o_in_ready) begin
                r_busy <= 1'b1;
                r_key  <= PAGE_BITS'(i_page);
            end else if (w_proceed) begin
                r_busy <= 1'b0;
            end
            if (w_proceed) begin
                r_out_valid <= 1'b1;
                r_fault     <= !w_hit[MAX_FRAMES];
                r_ev_valid  <= w_evict;
                r_ev_page   <= w_evict ? OUT_PAGE_W'(w_vpage[MAX_FRAMES]) : '0;
                if (!w_hit[MAX_FRAMES] && (r_fault_cnt != CNT_MAX)) begin
                    r_fault_cnt <= r_fault_cnt + CNT_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_fault         = r_fault;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_total   = r_fault_cnt;

    a_evict_is_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_ev_valid || r_fault))
        else $error("eviction reported without fault");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> $onehot0(w_match))
        else $error("page resident in more than one frame");

    a_evict_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_ev_valid) |-> (r_ev_page == '0))
        else $error("evicted page nonzero without eviction");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_fault_cnt >= $past(r_fault_cnt)))
        else $error("fault count decreased");

endmodule

`default_nettype wire

// File: sv/lrupr_cell.sv
`default_nettype none

module lrupr_cell #(
    parameter int PAGE_W = 16,
    parameter int RANK_W = 4
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire lrupr_pkg::t_cmd    i_cmd,
    input  wire                     i_active,
    input  wire  [PAGE_W-1:0]       i_key,
    input  wire  [RANK_W-1:0]       i_last_rank,
    input  wire  [RANK_W-1:0]       i_hit_rank,
    input  wire                     i_hit_chain,
    input  wire  [RANK_W-1:0]       i_rank_chain,
    input  wire                     i_free_chain,
    input  wire  [PAGE_W-1:0]       i_vpage_chain,
    output logic                    o_hit_chain,
    output logic [RANK_W-1:0]       o_rank_chain,
    output logic                    o_free_chain,
    output logic [PAGE_W-1:0]       o_vpage_chain,
    output logic                    o_match
);
    import lrupr_pkg::*;

    logic [PAGE_W-1:0] r_page;
    logic              r_valid;
    logic [RANK_W-1:0] r_rank;

    logic w_match;
    logic w_free;
    logic w_take_free;
    logic w_victim;

    assign w_match     = r_valid && i_active && (r_page == i_key);
    assign w_free      = i_active && !r_valid;
    assign w_take_free = w_free && !i_free_chain;
    assign w_victim    = r_valid && i_active && (r_rank == i_last_rank);

    assign o_match       = w_match;
    assign o_hit_chain   = i_hit_chain | w_match;
    assign o_rank_chain  = i_rank_chain | (w_match ? r_rank : '0);
    assign o_free_chain  = i_free_chain | w_free;
    assign o_vpage_chain = i_vpage_chain | (w_victim ? r_page : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.flush) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_cmd.update) begin
            priority if (i_cmd.hit) begin
                if (w_match) begin
                    r_rank <= '0;
                end else if (r_valid && (r_rank < i_hit_rank)) begin
                    r_rank <= r_rank + RANK_W'(1);
                end
            end else if (i_cmd.free_avail) begin
                if (w_take_free) begin
                    r_page  <= i_key;
                    r_valid <= 1'b1;
                    r_rank  <= '0;
                end else if (r_valid) begin
                    r_rank <= r_rank + RANK_W'(1);
                end
            end else begin
                if (w_victim) begin
                    r_page <= i_key;
                    r_rank <= '0;
                end else if (r_valid) begin
                    r_rank <= r_rank + RANK_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire
